[rtl/core/patb_pkg.sv]
// shared types and constants for the per-task alarm timer bank
// no dependencies; imported by patb_ctrl, patb_dpath and the top level
`default_nettype none

package patb_pkg;

    // bank size and derived index width
    localparam int NUM_TASKS = 16;
    localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    // field widths fixed by the interface
    localparam int TASK_W = 4;
    localparam int SECS_W = 32;
    localparam int TICK_W = 16;

    // input command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // result kind codes
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_FIRED = 1'b1;

    // prescaler reload value after reset
    localparam logic [TICK_W-1:0] TPS_RESET = TICK_W'(100);

    typedef logic [IDX_W-1:0] t_idx;

    // one timer entry as held in the memory
    typedef struct packed {
        logic [TICK_W-1:0] tick;
        logic [SECS_W-1:0] secs;
    } t_entry;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;    // latch the accepted input beat
        logic rd_en;      // read one entry
        logic rd_walk;    // the read belongs to a tick walk
        t_idx rd_addr;
        logic set_wr;     // apply the set and load its reply
        logic emit_load;  // load a fired result
        t_idx emit_idx;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;      // output register can take a beat this cycle
        logic any_fired;     // at least one timer expired on this tick
        logic fired_bit;     // timer at emit_idx expired
        logic fired_higher;  // some timer above emit_idx expired
    } t_status;

endpackage

`default_nettype wire

[rtl/core/patb_ctrl.sv]
// sequencer of the alarm timer bank: accept, set, walk and emit phases
// depends on patb_pkg; drives patb_dpath through t_cmd
`default_nettype none

module patb_ctrl
    import patb_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire logic         i_cmd,
    input  wire logic [3:0]   i_task_id,
    output logic              o_ready,
    input  wire t_status      i_status,
    output t_cmd              o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SET_WR   = 3'd1;
    localparam logic [2:0] S_WALK     = 3'd2;
    localparam logic [2:0] S_WALK_END = 3'd3;
    localparam logic [2:0] S_EMIT     = 3'd4;

    localparam t_idx LAST_IDX = t_idx'(NUM_TASKS - 1);

    logic [2:0] r_state, n_state;
    t_idx       r_idx, n_idx;

    // state and entry counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.emit_idx = r_idx;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_walk = (i_cmd == CMD_TICK);
                    o_cmd.rd_addr = (i_cmd == CMD_SET) ? t_idx'(i_task_id) : '0;
                    n_idx         = t_idx'(1);
                    if (i_cmd == CMD_SET) begin
                        n_state = S_SET_WR;
                    end else if (LAST_IDX == '0) begin
                        n_state = S_WALK_END;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_SET_WR: begin
                if (i_status.out_free) begin
                    o_cmd.set_wr = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_WALK: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_walk = 1'b1;
                o_cmd.rd_addr = r_idx;
                if (r_idx == LAST_IDX) begin
                    n_state = S_WALK_END;
                end else begin
                    n_idx = t_idx'(r_idx + 1'b1);
                end
            end
            S_WALK_END: begin
                // last entry is written back in this cycle
                n_idx   = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_status.any_fired) begin
                    n_state = S_IDLE;
                end else if (!i_status.fired_bit) begin
                    n_idx = t_idx'(r_idx + 1'b1);
                end else if (i_status.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (!i_status.fired_higher) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = t_idx'(r_idx + 1'b1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/patb_dpath.sv]
// datapath of the alarm timer bank: timer memory, active flags, fired mask,
// prescaler register and output register; depends on patb_pkg
`default_nettype none

module patb_dpath
    import patb_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [TICK_W-1:0]   i_cfg_data,
    input  wire logic [TASK_W-1:0]   i_task_id,
    input  wire logic [SECS_W-1:0]   i_seconds,
    input  wire t_cmd                i_cmd,
    output t_status                  o_status,
    input  wire logic                i_ready,
    output logic                     o_valid,
    output logic                     o_kind,
    output logic [TASK_W-1:0]        o_task_ref,
    output logic [SECS_W-1:0]        o_old_seconds,
    output logic                     o_last
);

    logic [TICK_W-1:0]    r_tps;
    logic [TASK_W-1:0]    r_in_task;
    logic [SECS_W-1:0]    r_in_secs;
    t_entry               r_mem [NUM_TASKS];
    t_entry               r_rd_data;
    logic                 r_rd_ok;
    logic                 r_rd_walk;
    t_idx                 r_rd_idx;
    logic [NUM_TASKS-1:0] r_valid;
    logic [NUM_TASKS-1:0] r_active;
    logic [NUM_TASKS-1:0] r_fired;
    logic                 r_out_vld;
    logic                 r_out_kind;
    logic [TASK_W-1:0]    r_out_task;
    logic [SECS_W-1:0]    r_out_old;
    logic                 r_out_last;

    t_entry            rd_eff;
    logic              in_range;
    logic [SECS_W-1:0] old_secs;
    logic              wb_hit;
    logic [TICK_W-1:0] tick_dec;
    logic [SECS_W-1:0] secs_dec;
    logic              wb_fire;
    logic              mem_we;
    t_idx              mem_wa;
    t_entry            mem_wd;
    logic [NUM_TASKS-1:0] fired_above;

    // prescaler reload register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TPS_RESET;
        end else if (i_cfg_we) begin
            r_tps <= i_cfg_data;
        end
    end

    // latched set operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_task <= i_task_id;
            r_in_secs <= i_seconds;
        end
    end

    // entry read, never-written entries read as zero
    assign rd_eff   = r_rd_ok ? r_rd_data : '0;
    assign in_range = (32'(r_in_task) < NUM_TASKS);
    assign old_secs = in_range ? rd_eff.secs : '0;

    // tick walk writeback of the entry read last cycle
    assign wb_hit   = r_rd_walk && r_active[r_rd_idx];
    assign tick_dec = TICK_W'(rd_eff.tick - 1'b1);
    assign secs_dec = SECS_W'(rd_eff.secs - 1'b1);
    assign wb_fire  = wb_hit && (tick_dec == '0) && (secs_dec == '0);

    // memory write mux
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_rd_idx;
        mem_wd = rd_eff;
        if (i_cmd.set_wr) begin
            mem_we = in_range;
            mem_wa = t_idx'(r_in_task);
            if (r_in_secs == '0) begin
                mem_wd.tick = rd_eff.tick;
                mem_wd.secs = '0;
            end else begin
                mem_wd.tick = r_tps;
                mem_wd.secs = r_in_secs;
            end
        end else if (wb_hit) begin
            mem_we = 1'b1;
            if (tick_dec != '0) begin
                mem_wd.tick = tick_dec;
                mem_wd.secs = rd_eff.secs;
            end else begin
                mem_wd.tick = r_tps;
                mem_wd.secs = secs_dec;
            end
        end
    end

    // timer memory with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end

    // read tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_walk <= 1'b0;
            r_rd_ok   <= 1'b0;
            r_rd_idx  <= '0;
        end else begin
            r_rd_walk <= i_cmd.rd_en && i_cmd.rd_walk;
            if (i_cmd.rd_en) begin
                r_rd_ok  <= r_valid[i_cmd.rd_addr];
                r_rd_idx <= i_cmd.rd_addr;
            end
        end
    end

    // per-entry written, active and fired flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_active <= '0;
            r_fired  <= '0;
        end else begin
            if (mem_we) begin
                r_valid[mem_wa] <= 1'b1;
            end
            if (i_cmd.set_wr && in_range) begin
                r_active[mem_wa] <= (r_in_secs != '0);
            end else if (wb_fire) begin
                r_active[r_rd_idx] <= 1'b0;
            end
            if (i_cmd.load_in) begin
                r_fired <= '0;
            end else if (wb_fire) begin
                r_fired[r_rd_idx] <= 1'b1;
            end
        end
    end

    // status for the sequencer
    assign fired_above           = (r_fired >> i_cmd.emit_idx) >> 1;
    assign o_status.out_free     = !r_out_vld || i_ready;
    assign o_status.any_fired    = |r_fired;
    assign o_status.fired_bit    = r_fired[i_cmd.emit_idx];
    assign o_status.fired_higher = |fired_above;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.set_wr || i_cmd.emit_load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_wr) begin
            r_out_kind <= KIND_REPLY;
            r_out_task <= r_in_task;
            r_out_old  <= old_secs;
            r_out_last <= 1'b1;
        end else if (i_cmd.emit_load) begin
            r_out_kind <= KIND_FIRED;
            r_out_task <= TASK_W'(i_cmd.emit_idx);
            r_out_old  <= '0;
            r_out_last <= !o_status.fired_higher;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_kind        = r_out_kind;
    assign o_task_ref    = r_out_task;
    assign o_old_seconds = r_out_old;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire

[rtl/core/per_task_alarm_timer_bank.sv]
// top level of the per-task alarm timer bank
// depends on patb_pkg, patb_ctrl and patb_dpath
//
// usage:
//   input channel i_valid/o_ready carries one beat: i_cmd, i_task_id,
//   i_seconds. a set beat (i_cmd = 1) arms a task's alarm, or cancels it
//   when i_seconds is zero, and gives one reply beat with the old seconds.
//   a tick beat (i_cmd = 0) steps every armed timer and gives one fired
//   beat per expiring task, in ascending task order, o_last on the final
//   one; a tick where nothing expires gives no beat.
//   output channel o_valid/i_ready is a registered beat.
//   i_cfg_we/i_cfg_data writes ticks_per_second (reset value 100); write
//   only while the block is idle.
// timing:
//   one beat is worked at a time. a set's reply is loaded in the set-write
//   state, once the output register is free. a tick walks the timer
//   memory one entry per cycle, then an emit pass steps up the task indices
//   to the last expiring one and loads one beat for each expiring task.
//   a stalled receiver holds the output beat and the sequencer waits.
// reset:
//   synchronous, active low; all timers come out disarmed with zero counts
//   and no clearing pass is needed.
`default_nettype none

module per_task_alarm_timer_bank
    import patb_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [TICK_W-1:0]   i_cfg_data,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic                i_cmd,
    input  wire logic [TASK_W-1:0]   i_task_id,
    input  wire logic [SECS_W-1:0]   i_seconds,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic                     o_kind,
    output logic [TASK_W-1:0]        o_task_ref,
    output logic [SECS_W-1:0]        o_old_seconds,
    output logic                     o_last
);

    t_cmd    cmd;
    t_status status;

    // sequencer
    patb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_cmd     (i_cmd),
        .i_task_id (i_task_id),
        .o_ready   (o_ready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    // timer storage and result path
    patb_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_task_id     (i_task_id),
        .i_seconds     (i_seconds),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_task_ref    (o_task_ref),
        .o_old_seconds (o_old_seconds),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire
